// ----- sv/rse_pkg.sv -----
// package: widths, constants and beat types of the rgb sobel edge magnitude block
package rse_pkg;

  localparam int unsigned MaxWidthDef = 2048;
  localparam int unsigned CfgW        = 12;
  localparam int unsigned PixW        = 24;

  localparam logic [CfgW-1:0] WidthReset  = 12'd640;
  localparam logic [CfgW-1:0] HeightReset = 12'd480;

  // register indexes
  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [10:0] out_col;
    logic [11:0] out_row;
    logic        frame_done;
  } out_beat_t;

  // sobel gradients of one 8-bit channel, window laid out as 9 bytes
  // p[r*3+c], r top..bottom, c left..right
  function automatic logic [16:0] sobel_sq_sum(input logic [8:0][7:0] p);
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [21:0] sx;
    logic [21:0] sy;
    gx = $signed({4'd0, p[0]}) - $signed({4'd0, p[2]})
       + $signed({3'd0, p[3], 1'b0}) - $signed({3'd0, p[5], 1'b0})
       + $signed({4'd0, p[6]}) - $signed({4'd0, p[8]});
    gy = $signed({4'd0, p[0]}) + $signed({3'd0, p[1], 1'b0}) + $signed({4'd0, p[2]})
       - $signed({4'd0, p[6]}) - $signed({3'd0, p[7], 1'b0}) - $signed({4'd0, p[8]});
    sx = 22'(gx * gx);
    sy = 22'(gy * gy);
    // anything at or above 65536 saturates, so clamp the sum to 17 bits
    sobel_sq_sum = ((sx + sy) > 22'd65535) ? 17'h10000 : 17'(sx + sy);
  endfunction

  // one restoring step of the square root: two radicand bits in, one root bit out
  typedef struct packed {
    logic [16:0] rem;
    logic [8:0]  root;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [16:0] v,
                                         input logic [3:0] k);
    sqrt_st_t   o;
    logic [18:0] r;
    logic [18:0] t;
    logic [17:0] vx;
    // top bit pair of the radicand is {0, v[16]}
    vx = {1'b0, v};
    r = {s.rem, vx[2*k+1 -: 2]};
    t = {8'd0, s.root, 2'b01};
    if (r >= 19'({s.root, 2'b01})) begin
      o.rem  = 17'(r - t);
      o.root = {s.root[7:0], 1'b1};
    end else begin
      o.rem  = 17'(r);
      o.root = {s.root[7:0], 1'b0};
    end
    sqrt_step = o;
  endfunction

endpackage

// ----- sv/rse_ram.sv -----
// generic simple dual-port ram: one write and one registered read per cycle
module rse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/rse_mag.sv -----
// three-channel sobel magnitude pipeline with registered square root stages
module rse_mag
  import rse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][8:0][7:0] win_i,
  input  logic                zero_i,
  input  logic [10:0]         col_i,
  input  logic [11:0]         row_i,
  input  logic                done_i,
  output logic                valid_o,
  output out_beat_t           beat_o
);

  // stage 0: squared sums, stages 1..3: three root bits each
  localparam int unsigned NStg = 4;

  typedef struct packed {
    logic       zero;
    logic [10:0] col;
    logic [11:0] row;
    logic       done;
  } side_t;

  logic [NStg-1:0]     vld_q;
  side_t [NStg-1:0]    side_q;
  logic [2:0][16:0]    val_q [NStg];
  sqrt_st_t [2:0]      st_q  [NStg];

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NStg-2:0], valid_i};
    end
  end

  // squared sums and root iterations
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{zero: zero_i, col: col_i, row: row_i, done: done_i};
      for (int c = 0; c < 3; c++) begin
        val_q[0][c] <= sobel_sq_sum(win_i[c]);
        st_q[0][c]  <= '0;
      end
      for (int s = 1; s < NStg; s++) begin
        side_q[s] <= side_q[s-1];
        for (int c = 0; c < 3; c++) begin
          sqrt_st_t t;
          t = st_q[s-1][c];
          for (int k = 0; k < 3; k++) begin
            t = sqrt_step(t, val_q[s-1][c], 4'(8 - 3*(s-1) - k));
          end
          val_q[s][c] <= val_q[s-1][c];
          st_q[s][c]  <= t;
        end
      end
    end
  end

  // 9 root bits: 3 stages cover 8..0; root 256 only for the clamped sum
  logic [2:0][7:0] mag;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = st_q[NStg-1][c].root[8] ? 8'hff : st_q[NStg-1][c].root[7:0];
      if (side_q[NStg-1].zero) mag[c] = 8'd0;
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign beat_o  = '{out_red: mag[0], out_green: mag[1], out_blue: mag[2],
                     out_col: side_q[NStg-1].col, out_row: side_q[NStg-1].row,
                     frame_done: side_q[NStg-1].done};

endmodule

// ----- sv/rgb_sobel_edge_magnitude.sv -----
// top level: rgb sobel edge magnitude over a raster pixel stream
//
//  channel | dir | handshake            | beat
//  in      | in  | in_valid_i/ready_o   | in_beat_t (r, g, b)
//  out     | out | out_valid_o/ready_i  | out_beat_t (r, g, b, col, row, done)
//  cfg     | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// a new input pixel is taken only once the last is done: accept, line store read,
// then its result beats in turn (the emit state is passed even for none, up to three).
// the line store is one ram (row y-1 and row y-2 packed in one 48-bit word),
// read when a pixel is taken and written back in the next cycle; the window
// shifts as the pixel's last result, if any, enters the 4-stage magnitude pipeline.
// a stalled output register freezes the pipeline when its last slot is valid, and holds the sequencer in emit.
// reset clears position, window and pipeline; the line store needs no clearing.
module rgb_sobel_edge_magnitude
  import rse_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_beat_t        in_beat_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_beat_t       out_beat_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned AddrW  = $clog2(MaxWidth);
  localparam int unsigned CntW   = CfgW;
  // the width register cannot ask for more than its own range
  localparam int unsigned MaxEff = (MaxWidth < (2**CfgW - 1)) ? MaxWidth : (2**CfgW - 1);
  localparam logic [CfgW:0] MaxW = (CfgW+1)'(MaxEff);

  typedef enum logic [1:0] {StIdle, StRead, StEmit} state_e;

  state_e            state_q;
  logic [CfgW-1:0]   width_q, height_q;
  logic [CntW-1:0]   col_q;
  logic [11:0]       row_q;
  in_beat_t          pix_q;
  logic [PixW-1:0]   wa_q [3]; // column x-2: top, mid, bot
  logic [PixW-1:0]   wb_q [3]; // column x-1: top, mid, bot
  logic [2:0]        pend_q;   // queued results: main, right zero, bottom zero
  logic [CntW-1:0]   x_q;
  logic [11:0]       y_q;
  logic [2*PixW-1:0] rd;

  // effective frame size with clamping
  logic [CfgW:0]   w_eff;
  logic [11:0]     h_eff;
  always_comb begin
    w_eff = (width_q < 12'd3) ? 13'd3 : {1'b0, width_q};
    if (w_eff > MaxW) w_eff = MaxW;
    h_eff = (height_q < 12'd3) ? 12'd3 : height_q;
  end

  logic [CntW-1:0] wm1;
  assign wm1 = CntW'(w_eff - 13'd1);

  logic take;
  assign in_ready_o = (state_q == StIdle);
  assign take = in_valid_i && in_ready_o;

  // position of the taken pixel, wrapping when out of frame
  logic [CntW-1:0] x_cur;
  logic [11:0]     y_cur;
  always_comb begin
    x_cur = col_q;
    y_cur = row_q;
    if ({{(CfgW+1-CntW){1'b0}}, col_q} >= w_eff || row_q >= h_eff) begin
      x_cur = '0;
      y_cur = '0;
    end
  end

  // line store ram: {row y-2, row y-1}
  logic ram_we;
  assign ram_we = (state_q == StRead);
  rse_ram #(.Width(2*PixW), .Depth(MaxWidth)) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(x_q)),
    .wdata_i ({rd[PixW-1:0], pix_q}),
    .re_i    (take),
    .raddr_i (AddrW'(x_cur)),
    .rdata_o (rd)
  );

  // magnitude pipeline feed
  logic [2:0][8:0][7:0] win;
  logic [PixW-1:0] top, mid;
  assign top = rd[2*PixW-1:PixW];
  assign mid = rd[PixW-1:0];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      win[c][0] = wa_q[0][8*(2-c) +: 8];
      win[c][3] = wa_q[1][8*(2-c) +: 8];
      win[c][6] = wa_q[2][8*(2-c) +: 8];
      win[c][1] = wb_q[0][8*(2-c) +: 8];
      win[c][4] = wb_q[1][8*(2-c) +: 8];
      win[c][7] = wb_q[2][8*(2-c) +: 8];
      win[c][2] = top[8*(2-c) +: 8];
      win[c][5] = mid[8*(2-c) +: 8];
      win[c][8] = pix_q[8*(2-c) +: 8];
    end
  end

  // pick the next result of the current pixel
  logic        feed;
  logic        f_zero;
  logic [10:0] f_col;
  logic [11:0] f_row;
  logic        f_done;
  logic [2:0]  pend_n;
  logic        out_free;
  logic        mag_vld;
  out_beat_t   mag_beat;

  always_comb begin
    f_zero = 1'b1;
    f_col  = 11'(x_q);
    f_row  = y_q;
    f_done = 1'b0;
    pend_n = pend_q;
    if (pend_q[0]) begin
      f_zero = !(x_q >= CntW'(2) && y_q >= 12'd2);
      f_col  = 11'(x_q - CntW'(1));
      f_row  = y_q - 12'd1;
      pend_n[0] = 1'b0;
    end else if (pend_q[1]) begin
      f_col  = 11'(wm1);
      f_row  = y_q - 12'd1;
      pend_n[1] = 1'b0;
    end else begin
      f_col  = 11'(x_q);
      f_row  = h_eff - 12'd1;
      f_done = (x_q == wm1);
      pend_n[2] = 1'b0;
    end
  end

  // pipeline moves when its last slot can go to the output register
  logic en;
  assign en = !(mag_vld && out_valid_o && !out_ready_i);
  assign feed = (state_q == StEmit) && (pend_q != 3'b000) && en;

  rse_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (feed),
    .win_i   (win),
    .zero_i  (f_zero),
    .col_i   (f_col),
    .row_i   (f_row),
    .done_i  (f_done),
    .valid_o (mag_vld),
    .beat_o  (mag_beat)
  );

  // output register
  assign out_free = !out_valid_o || out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= mag_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (out_free && mag_vld) begin
      out_beat_o <= mag_beat;
    end
  end

  // sequencer, position, window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
      x_q      <= '0;
      y_q      <= '0;
      pix_q    <= '0;
      for (int r = 0; r < 3; r++) begin
        wa_q[r] <= '0;
        wb_q[r] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgIdxWidth) width_q <= cfg_data_i;
        if (cfg_idx_i == CfgIdxHeight) height_q <= cfg_data_i;
        col_q <= '0;
        row_q <= '0;
      end
      case (state_q)
        StIdle: begin
          if (take) begin
            pix_q <= in_beat_i;
            x_q   <= x_cur;
            y_q   <= y_cur;
            pend_q <= {y_cur == h_eff - 12'd1,
                       y_cur >= 12'd1 && x_cur == wm1,
                       y_cur >= 12'd1 && x_cur >= CntW'(1)};
            if (x_cur == wm1) begin
              col_q <= '0;
              row_q <= (y_cur == h_eff - 12'd1) ? 12'd0 : y_cur + 12'd1;
            end else begin
              col_q <= x_cur + CntW'(1);
              row_q <= y_cur;
            end
            state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= StEmit;
        end
        StEmit: begin
          if (feed) pend_q <= pend_n;
          if (pend_q == 3'b000 || (feed && pend_n == 3'b000)) begin
            wa_q[0] <= wb_q[0];
            wa_q[1] <= wb_q[1];
            wa_q[2] <= wb_q[2];
            wb_q[0] <= top;
            wb_q[1] <= mid;
            wb_q[2] <= pix_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- sv/rse_checker.sv -----
// port-level checker for the rgb sobel edge magnitude block, bound to the top level
module rse_checker
  import rse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_o,
  input  logic      out_valid_o,
  input  logic      out_ready_i,
  input  out_beat_t out_beat_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  // in_ready_o drops after every taken pixel
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("pixel taken on back-to-back cycles");

  // a frame end beat carries a zero pixel
  a_done_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.frame_done |-> out_beat_o.out_red == 8'd0 &&
    out_beat_o.out_green == 8'd0 && out_beat_o.out_blue == 8'd0)
    else $error("frame end on a non-zero pixel");

  // pixels in column 0 or row 0 have zero red and blue
  a_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.out_col == 11'd0 || out_beat_o.out_row == 12'd0) |->
    out_beat_o.out_red == 8'd0 && out_beat_o.out_blue == 8'd0)
    else $error("non-zero border pixel");

endmodule

bind rgb_sobel_edge_magnitude rse_checker u_rse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);

// ----- dv/tb.sv -----
// testbench: rgb sobel edge magnitude against an in-bench pixel predictor
module tb;
  import rse_pkg::*;

  // pixel predictor and store of expected result beats
  class sobel_board;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [23:0] line_mem[2*MaxWidthDef];
    logic [23:0] win[6];
    int unsigned col_pos;
    int unsigned row_pos;
    out_beat_t   pending_q[$];
    int          errors;

    function new();
      width_reg = WidthReset;
      height_reg = HeightReset;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [11:0] val);
      if (idx == CfgIdxWidth) width_reg = val;
      else height_reg = val;
      col_pos = 0;
      row_pos = 0;
    endfunction

    function int unsigned root_floor(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    endfunction

    // magnitude of one channel, window p[row][col]
    function logic [7:0] chan_mag(logic [23:0] p[3][3], int sh);
      int v[3][3];
      int gx;
      int gy;
      int unsigned m;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) v[r][c] = (p[r][c] >> sh) & 8'hff;
      gx = v[0][0] - v[0][2] + 2*v[1][0] - 2*v[1][2] + v[2][0] - v[2][2];
      gy = v[0][0] + 2*v[0][1] + v[0][2] - v[2][0] - 2*v[2][1] - v[2][2];
      m = root_floor(gx*gx + gy*gy);
      return (m > 255) ? 8'd255 : m[7:0];
    endfunction

    function void push(logic [23:0] rgb, int unsigned col, int unsigned row, bit done);
      out_beat_t b;
      b.out_red = rgb[23:16];
      b.out_green = rgb[15:8];
      b.out_blue = rgb[7:0];
      b.out_col = col[10:0];
      b.out_row = row[11:0];
      b.frame_done = done;
      pending_q.push_back(b);
    endfunction

    // note an accepted input pixel
    function void note_pixel(in_beat_t pin);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      logic [23:0] pix;
      logic [23:0] top;
      logic [23:0] mid;
      logic [23:0] rgb;
      logic [23:0] p[3][3];
      w = (width_reg < 3) ? 3 : width_reg;
      if (w > MaxWidthDef) w = MaxWidthDef;
      h = (height_reg < 3) ? 3 : height_reg;
      x = col_pos;
      y = row_pos;
      if (x >= w || y >= h) begin
        x = 0;
        y = 0;
      end
      pix = pin;
      top = line_mem[MaxWidthDef + x];
      mid = line_mem[x];
      line_mem[MaxWidthDef + x] = mid;
      line_mem[x] = pix;
      if (y >= 1 && x >= 1) begin
        rgb = '0;
        if (x >= 2 && y >= 2) begin
          for (int r = 0; r < 3; r++) begin
            p[r][0] = win[r];
            p[r][1] = win[3+r];
          end
          p[0][2] = top;
          p[1][2] = mid;
          p[2][2] = pix;
          rgb = {chan_mag(p, 16), chan_mag(p, 8), chan_mag(p, 0)};
        end
        push(rgb, x - 1, y - 1, 0);
      end
      if (y >= 1 && x == w - 1) push('0, w - 1, y - 1, 0);
      if (y == h - 1) push('0, x, h - 1, x == w - 1);
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = pix;
      if (x + 1 >= w) begin
        col_pos = 0;
        row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col_pos = x + 1;
        row_pos = y;
      end
    endfunction

    // check one result beat against the oldest expectation
    function void check_result(out_beat_t got);
      out_beat_t exp_b;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_b = pending_q.pop_front();
      if (got.out_red !== exp_b.out_red) begin
        $display("%0t: red exp %0d got %0d", $time, exp_b.out_red, got.out_red);
        errors++;
      end
      if (got.out_green !== exp_b.out_green) begin
        $display("%0t: green exp %0d got %0d", $time, exp_b.out_green, got.out_green);
        errors++;
      end
      if (got.out_blue !== exp_b.out_blue) begin
        $display("%0t: blue exp %0d got %0d", $time, exp_b.out_blue, got.out_blue);
        errors++;
      end
      if (got.out_col !== exp_b.out_col) begin
        $display("%0t: col exp %0d got %0d", $time, exp_b.out_col, got.out_col);
        errors++;
      end
      if (got.out_row !== exp_b.out_row) begin
        $display("%0t: row exp %0d got %0d", $time, exp_b.out_row, got.out_row);
        errors++;
      end
      if (got.frame_done !== exp_b.frame_done) begin
        $display("%0t: done exp %0d got %0d", $time, exp_b.frame_done, got.frame_done);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  in_beat_t        in_beat_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_beat_t       out_beat_o;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  sobel_board board;
  bit         sink_idle_on;
  bit         sink_hold;
  bit         src_idle_on;

  rgb_sobel_edge_magnitude dut (.*);

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // result side: random stalls, checks on every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_beat_o);
    out_ready_i <= !sink_hold && !(sink_idle_on && $urandom_range(99) < 25);
  end

  // long hold-off of the receiver, counted in cycles
  task automatic hold_sink(int unsigned cycles);
    sink_hold = 1'b1;
    repeat (cycles) @(posedge clk_i);
    sink_hold = 1'b0;
  endtask

  // offer one pixel and wait for its acceptance
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (src_idle_on && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= {r, g, b};
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pixel({r, g, b});
  endtask

  task automatic send_random_pixel();
    send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // wait until all results are in, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // one register write, with write enable low again before the task returns
  task automatic write_reg(logic idx, logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_frame(logic [11:0] w, logic [11:0] h);
    drain();
    write_reg(CfgIdxWidth, w);
    write_reg(CfgIdxHeight, h);
  endtask

  // main sequence
  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgIdxWidth;
    cfg_data_i = '0;
    sink_idle_on = 1'b0;
    sink_hold = 1'b0;
    src_idle_on = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3x3 frame, extremes and a strong edge for saturation
    set_frame(12'd3, 12'd3);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    // out-of-range sizes clamp to the minimum
    set_frame(12'd0, 12'd1);
    repeat (9) send_random_pixel();
    // width above the line store limit clamps, then a size write mid-frame
    set_frame(12'd4095, 12'd3);
    repeat (5) send_random_pixel();
    set_frame(12'd5, 12'd4);
    repeat (20) send_random_pixel();

    // random: several sizes, idling on both sides
    sink_idle_on = 1'b1;
    src_idle_on = 1'b1;
    set_frame(12'd7, 12'd5);
    repeat (80) send_random_pixel();
    fork
      hold_sink(200);
      repeat (60) send_random_pixel();
    join
    set_frame(12'd2048, 12'd3);
    repeat (20) send_random_pixel();
    set_frame(12'd4, 12'd4095);
    repeat (100) send_random_pixel();
    set_frame(12'd3, 12'd6);
    repeat (60) send_random_pixel();
    sink_idle_on = 1'b0;
    src_idle_on = 1'b0;
    repeat (60) send_random_pixel();
    sink_idle_on = 1'b1;
    src_idle_on = 1'b1;
    set_frame(WidthReset, HeightReset);
    repeat (40) send_random_pixel();
    drain();

    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("rgb_sobel_edge_magnitude: match");
    else
      $display("rgb_sobel_edge_magnitude: mismatch");
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("rgb_sobel_edge_magnitude: mismatch");
    $finish;
  end

endmodule
